// ===== rtl/core/hbsn_pkg.sv =====
// Package for the HDLC bit stuffing / NRZI serializer.
// Holds field widths, symbol counts and configuration register indexes.
// No dependencies.
`default_nettype none

package hbsn_pkg;

    localparam int DATA_W     = 8;   // frame byte width
    localparam int POS_W      = 4;   // byte position within the frame
    localparam int ONES_W     = 3;   // counted ones / run limit width
    localparam int TAKEN_W    = 4;   // data bits taken, 0..8
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;   // widest register: start_flag_bytes
    localparam int M_TDATA_W  = 8;
    localparam int M_TUSER_W  = 2;

    localparam logic [TAKEN_W-1:0] SYM_BITS = TAKEN_W'(DATA_W);
    localparam logic [POS_W-1:0]   POS_MAX  = '1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_START_FLAG_BYTES = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ONES_RUN_LIMIT   = 1'b1;

    localparam logic [POS_W-1:0]  START_FLAG_BYTES_RST = 4'd2;
    localparam logic [ONES_W-1:0] ONES_RUN_LIMIT_RST   = 3'd5;

    // Fields of one output symbol
    typedef struct packed {
        logic run_last;
        logic frame_end;
        logic stuffed;
        logic line_level;
    } sym_t;

endpackage

`default_nettype wire

// ===== rtl/core/hdlc_bit_stuff_nrzi_serializer_core.sv =====
// A byte is registered on transfer, and its first symbol moves to the output register
// once that stage is free. Throughput: one symbol per cycle while m_tready keeps the
// output moving (8 data bits plus up to two stuffed zeros per byte); the single symbol
// stage sets this rate. The next byte is taken as the current byte's last symbol moves
// to the output register. Reset (aresetn, synchronous, active low) clears frame state
// and restores the configuration defaults: start_flag_bytes = 2, ones_run_limit = 5.
`default_nettype none

module hdlc_bit_stuff_nrzi_serializer_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [hbsn_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [hbsn_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input byte stream
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire logic [hbsn_pkg::DATA_W-1:0]     s_tdata,   // [7:0] data_byte
    input  wire logic                            s_tlast,   // frame_last
    // output symbol stream
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [hbsn_pkg::M_TDATA_W-1:0]  m_tdata,   // [0] line_level, [7:1] zero
    output      logic [hbsn_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] stuffed, [1] frame_end
    output      logic                            m_tlast    // run_last
);
    import hbsn_pkg::*;

    // Configuration registers
    logic [POS_W-1:0]  start_flag_bytes_reg;
    logic [ONES_W-1:0] ones_run_limit_reg;

    // Byte under serialization
    logic                busy_reg;
    logic [DATA_W-1:0]   data_reg;
    logic                last_reg;
    logic                may_stuff_reg;
    logic                may_count_reg;
    logic [TAKEN_W-1:0]  taken_reg;
    logic [1:0]          stuff_cnt_reg;

    // Frame state
    logic [POS_W-1:0]    byte_pos_reg;
    logic                prev_level_reg;
    logic [ONES_W-1:0]   ones_count_reg;
    logic                stuff_pending_reg;

    // Output register
    logic                m_valid_reg;
    sym_t                sym_reg;

    // Symbol step signals
    logic                advance;
    logic                s_fire;
    logic                stuff;
    logic                bit_val;
    logic [ONES_W-1:0]   lim;
    logic [ONES_W-1:0]   ones_inc;
    logic [ONES_W-1:0]   ones_count_next;
    logic                stuff_pending_next;
    logic                level_next;
    logic [TAKEN_W-1:0]  taken_next;
    logic                byte_done;
    sym_t                sym_next;

    // Configuration decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_flag_bytes_reg <= START_FLAG_BYTES_RST;
            ones_run_limit_reg   <= ONES_RUN_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_START_FLAG_BYTES: start_flag_bytes_reg <= cfg_wdata;
                CFG_ONES_RUN_LIMIT:   ones_run_limit_reg   <= cfg_wdata[ONES_W-1:0];
                default: ;
            endcase
        end
    end

    // Emit a symbol whenever a byte is active and the output stage is free or drains.
    assign advance = busy_reg && (!m_valid_reg || m_tready);

    // A limit of zero behaves as one.
    assign lim = (ones_run_limit_reg == '0) ? ONES_W'(1) : ones_run_limit_reg;

    always_comb begin
        // Insert a zero only while the budget allows: at most two stuffs per byte.
        stuff   = stuff_pending_reg && may_stuff_reg && !stuff_cnt_reg[1];
        bit_val = stuff ? 1'b0 : data_reg[taken_reg[2:0]];
        taken_next = stuff ? taken_reg : taken_reg + TAKEN_W'(1);

        ones_inc = ones_count_reg + ONES_W'(1);
        if (bit_val && may_count_reg) begin
            ones_count_next    = ones_inc;
            stuff_pending_next = stuff_pending_reg;
        end else begin
            ones_count_next    = '0;
            stuff_pending_next = 1'b0;
        end
        // Run limit reached: request a stuff and restart the count.
        if (ones_count_next >= lim) begin
            stuff_pending_next = 1'b1;
            ones_count_next    = '0;
        end

        // NRZI: a zero toggles the line, a one holds it.
        level_next = bit_val ? prev_level_reg : ~prev_level_reg;
        byte_done  = (taken_next == SYM_BITS);

        sym_next.line_level = level_next;
        sym_next.stuffed    = stuff;
        sym_next.frame_end  = byte_done && last_reg;
        sym_next.run_last   = byte_done;
    end

    // Take a new byte when idle or as the current one finishes.
    assign s_tready = !busy_reg || (advance && byte_done);
    assign s_fire   = s_tvalid && s_tready;

    // Working byte and per-byte permissions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            byte_pos_reg <= '0;
        end else begin
            if (s_fire) begin
                busy_reg <= 1'b1;
                // Advance the frame position; a last byte starts the next frame at zero.
                if (s_tlast) begin
                    byte_pos_reg <= '0;
                end else if (byte_pos_reg != POS_MAX) begin
                    byte_pos_reg <= byte_pos_reg + POS_W'(1);
                end
            end else if (advance && byte_done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            data_reg      <= s_tdata;
            last_reg      <= s_tlast;
            may_stuff_reg <= !s_tlast && (byte_pos_reg >= start_flag_bytes_reg);
            may_count_reg <= !s_tlast && (byte_pos_reg != '0);
            taken_reg     <= '0;
            stuff_cnt_reg <= '0;
        end else if (advance) begin
            taken_reg <= taken_next;
            if (stuff) begin
                stuff_cnt_reg <= stuff_cnt_reg + 2'd1;
            end
        end
    end

    // Line and run state; drop everything after the final symbol of a frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg    <= 1'b0;
            ones_count_reg    <= '0;
            stuff_pending_reg <= 1'b0;
        end else if (advance) begin
            if (byte_done && last_reg) begin
                prev_level_reg    <= 1'b0;
                ones_count_reg    <= '0;
                stuff_pending_reg <= 1'b0;
            end else begin
                prev_level_reg    <= level_next;
                ones_count_reg    <= ones_count_next;
                stuff_pending_reg <= stuff_pending_next;
            end
        end
    end

    // Output register: hold while stalled, load on each symbol step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sym_reg <= sym_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, sym_reg.line_level};
    assign m_tuser  = {sym_reg.frame_end, sym_reg.stuffed};
    assign m_tlast  = sym_reg.run_last;

endmodule

`default_nettype wire
